>>> src/sq_pkg.sv
// Shared constants, types and ring arithmetic for the stack-ended queue.
// No dependencies; the top level and sq_ctrl import this package, sq_ram does not.
`timescale 1ns / 1ps

package sq_pkg;

    // store geometry
    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // field widths
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CYCLE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

    // controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // one access to the entry memory
    typedef struct packed {
        logic                  wr_en;
        logic [PTR_W-1:0]      wr_addr;
        logic [ITEM_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [PTR_W-1:0]      rd_addr;
    } mem_req_t;

    // one result transfer
    typedef struct packed {
        logic [ITEM_WIDTH-1:0] item;
        logic                  valid;
        logic [STAT_W-1:0]     status;
        logic [CNT_W-1:0]      occupancy;
    } result_t;

    // slot at a given offset from the head, modulo the depth
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // slot just before the head, modulo the depth
    function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] head);
        logic [PTR_W-1:0] slot;
        if (head == '0)
        begin
            slot = PTR_W'(DEPTH - 1);
        end
        else
        begin
            slot = head - PTR_W'(1);
        end
        return slot;
    endfunction

endpackage

>>> src/stack_ended_queue.sv
// Top level of the stack-ended queue: sequencer, entry memory and result register.
// Depends on sq_pkg, sq_ram and sq_ctrl.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. Enqueue, push, unknown
// commands and any command that finds the store empty (or full, for the two
// writes) retire at once and leave busy low, so one may follow in every cycle.
// Pop, peek and cycle on a non-empty store first read the front entry from the
// single-port-read entry memory, whose read data is registered, and busy is
// high in the read state while that data returns. Each result is marked by
// done for exactly one cycle, in the cycle after the command retires; it must be
// captured then, as there is no way to hold it.
// The entry memory has no clearing pass: after reset the block is ready at once.

module stack_ended_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [sq_pkg::CMD_W-1:0]       command,
    input  logic [sq_pkg::ITEM_WIDTH-1:0]  item_in,
    output logic                           busy,
    output logic                           done,
    output logic [sq_pkg::ITEM_WIDTH-1:0]  item_out,
    output logic                           item_valid,
    output logic [sq_pkg::STAT_W-1:0]      status,
    output logic [sq_pkg::CNT_W-1:0]       occupancy
);

    import sq_pkg::*;

    mem_req_t              mem_req;
    logic [ITEM_WIDTH-1:0] rd_data;
    logic                  res_load;
    result_t               res;

    logic                  done_reg;
    result_t               res_reg;

    // command sequencer
    sq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .item_in  (item_in),
        .rd_data  (rd_data),
        .busy     (busy),
        .mem_req  (mem_req),
        .res_load (res_load),
        .res      (res)
    );

    // entry memory
    sq_ram #(
        .DATA_W (ITEM_WIDTH),
        .ADDR_W (PTR_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign done       = done_reg;
    assign item_out   = res_reg.item;
    assign item_valid = res_reg.valid;
    assign status     = res_reg.status;
    assign occupancy  = res_reg.occupancy;

endmodule

>>> src/sq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency; sized by its parameters.
`timescale 1ns / 1ps

module sq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4,
    parameter int WORDS  = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/sq_ctrl.sv
// Command sequencer: head and count registers, memory requests and result forming.
// Depends on sq_pkg; drives the entry memory in sq_ram.
`timescale 1ns / 1ps

module sq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sq_pkg::CMD_W-1:0]      command,
    input  logic [sq_pkg::ITEM_WIDTH-1:0] item_in,
    input  logic [sq_pkg::ITEM_WIDTH-1:0] rd_data,
    output logic                          busy,
    output sq_pkg::mem_req_t              mem_req,
    output logic                          res_load,
    output sq_pkg::result_t               res
);

    import sq_pkg::*;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;

    logic accept;
    logic empty;
    logic full;
    logic needs_read;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg >= CNT_W'(DEPTH));

    // commands that need the front entry from memory
    assign needs_read = !empty &&
                        (command == CMD_POP || command == CMD_CYCLE || command == CMD_PEEK);

    // next state, memory access and result
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        mem_req    = '0;
        res_load   = 1'b0;
        res        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && needs_read)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg;
                    cmd_next        = command;
                    state_next      = ST_READ;
                end
                else if (accept)
                begin
                    res_load = 1'b1;
                    case (command)
                        CMD_ENQUEUE:
                        begin
                            if (full)
                            begin
                                res.status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = ring_add(head_reg, count_reg);
                                mem_req.wr_data = item_in;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH:
                        begin
                            if (full)
                            begin
                                res.status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                head_next       = ring_dec(head_reg);
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = ring_dec(head_reg);
                                mem_req.wr_data = item_in;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        // only reached here when the store is empty
                        CMD_POP, CMD_PEEK:
                        begin
                            res.status = STAT_UNDERFLOW;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
                case (cmd_reg)
                    CMD_POP:
                    begin
                        res.item   = rd_data;
                        res.valid  = 1'b1;
                        head_next  = ring_add(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                    CMD_PEEK:
                    begin
                        res.item  = rd_data;
                        res.valid = 1'b1;
                    end
                    // front goes behind the last entry, then the head moves on
                    CMD_CYCLE:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ring_add(head_reg, count_reg);
                        mem_req.wr_data = rd_data;
                        head_next       = ring_add(head_reg, CNT_W'(1));
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.occupancy = count_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // held command while the front entry is read
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // count never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // the read state follows an accepted command that issued a read
    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(accept && mem_req.rd_en))
        else $error("read state without a read request");

    // a memory read and write never share a cycle
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("read and write in the same cycle");

    // an accepted command that issues a read produces its result from the read state and returns to idle
    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mem_req.rd_en) |=> (res_load && state_next == ST_IDLE))
        else $error("read command did not complete");

    // the store is never seen empty while a pop, peek or cycle retires from the read state
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !empty)
        else $error("front read on an empty store");

endmodule
